// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the actuator frame parser RTL.
// The enclosing module must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ACFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ACFP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ACFP_ASSERT(lbl, prop, msg)
`define ACFP_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/acfp_pkg.sv =====
`default_nettype none
package acfp_pkg;

    localparam int ACT_MAX_DEF    = 16;
    localparam int VALUE_BITS_DEF = 16;

    localparam int INDEX_W    = 16;
    localparam int COUNT_W    = 5;
    localparam int READ_IDX_W = 4;
    localparam int OUT_W      = 16;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [7:0] CHAR_OPEN  = 8'h7B;
    localparam logic [7:0] CHAR_CLOSE = 8'h7D;
    localparam logic [7:0] CHAR_SEP   = 8'h3B;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

endpackage
`default_nettype wire

// ===== hw/rtl/actuator_command_frame_parser.sv =====
// Actuator command frame parser.
// The input channel (i_in_valid / o_in_ready) carries one item per
// handshake: a received serial byte (kind 0) or a read of one actuator
// slot (kind 1). Bytes form frames "{index;value}"; a closed frame with
// an index below the configured count stores the value and raises the
// new-data flag, which a read returns and then clears.
// The output channel (o_out_valid / i_out_ready) gives one result per
// item, in the cycle after the item is accepted. Every item is finished in
// a single pass from the parser state registers into the result
// register, so one item is taken per cycle for as long as the receiver
// keeps up. When the receiver stalls, the result register holds and
// o_in_ready drops until the result is taken.
// Writing the count (i_cfg_we) clears the whole store. Synchronous reset
// clears the count, the store valid bits, the new-data flag and the
// frame parser; the result register is empty after reset.
`default_nettype none
`include "assert_macros.svh"
module actuator_command_frame_parser #(
    parameter int ACT_MAX    = acfp_pkg::ACT_MAX_DEF,
    parameter int VALUE_BITS = acfp_pkg::VALUE_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [acfp_pkg::COUNT_W-1:0]     i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic                             i_kind,
    input  wire logic [7:0]                       i_rx_byte,
    input  wire logic [acfp_pkg::READ_IDX_W-1:0]  i_read_index,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_frame_done,
    output logic                                  o_frame_accepted,
    output logic signed [acfp_pkg::OUT_W-1:0]     o_read_value,
    output logic                                  o_new_data
);

    localparam int AW = (ACT_MAX > 1) ? $clog2(ACT_MAX) : 1;

    logic r_in_frame, n_in_frame;
    logic r_seen_sep, n_seen_sep;
    logic r_new_data, n_new_data;
    logic r_out_valid;
    logic r_frame_done;
    logic r_frame_acc;
    logic r_out_new_data;

    logic accept;
    logic is_byte;
    logic is_read;
    logic is_open;
    logic is_close;
    logic is_sep;
    logic close_hit;
    logic body_char;
    logic idx_clear;
    logic idx_feed;
    logic val_clear;
    logic val_feed;
    logic idx_ok;
    logic wr_en;

    logic                          idx_neg;
    logic [acfp_pkg::INDEX_W-1:0]  idx_acc;
    logic                          val_neg;
    logic [VALUE_BITS-1:0]         val_acc;
    logic [VALUE_BITS-1:0]         val_store;
    logic [acfp_pkg::COUNT_W-1:0]  count;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign is_byte    = accept && (i_kind == acfp_pkg::KIND_BYTE);
    assign is_read    = accept && (i_kind == acfp_pkg::KIND_READ);

    assign is_open   = (i_rx_byte == acfp_pkg::CHAR_OPEN);
    assign is_close  = (i_rx_byte == acfp_pkg::CHAR_CLOSE);
    assign is_sep    = (i_rx_byte == acfp_pkg::CHAR_SEP);
    assign close_hit = is_byte && is_close && r_in_frame;
    assign body_char = is_byte && r_in_frame && !is_open && !is_close;

    // Until the first separator, the index and the value read the same text.
    assign idx_clear = (is_byte && is_open) || close_hit;
    assign idx_feed  = body_char && !r_seen_sep;
    assign val_clear = idx_clear || (body_char && is_sep && !r_seen_sep);
    assign val_feed  = body_char && !(is_sep && !r_seen_sep);

    acfp_num_feed #(
        .ACC_W    (acfp_pkg::INDEX_W),
        .SATURATE (1'b1)
    ) u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (idx_clear),
        .i_feed  (idx_feed),
        .i_char  (i_rx_byte),
        .o_neg   (idx_neg),
        .o_acc   (idx_acc)
    );

    acfp_num_feed #(
        .ACC_W    (VALUE_BITS),
        .SATURATE (1'b0)
    ) u_value (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (val_clear),
        .i_feed  (val_feed),
        .i_char  (i_rx_byte),
        .o_neg   (val_neg),
        .o_acc   (val_acc)
    );

    // A minus sign is tolerated only on an index of zero.
    assign idx_ok    = !(idx_neg && (idx_acc != '0))
                    && (idx_acc < acfp_pkg::INDEX_W'(count));
    assign wr_en     = close_hit && idx_ok;
    assign val_store = val_neg ? (VALUE_BITS'(0) - val_acc) : val_acc;

    acfp_store #(
        .ACT_MAX    (ACT_MAX),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_wr_en    (wr_en),
        .i_wr_addr  (AW'(idx_acc)),
        .i_wr_data  (val_store),
        .i_rd_en    (accept),
        .i_rd_sel   (is_read),
        .i_rd_idx   (i_read_index),
        .o_count    (count),
        .o_rd_value (o_read_value)
    );

    always_comb begin
        n_in_frame = r_in_frame;
        n_seen_sep = r_seen_sep;
        n_new_data = r_new_data;
        if (is_read) begin
            n_new_data = 1'b0;
        end else if (is_byte) begin
            if (is_open) begin
                n_in_frame = 1'b1;
                n_seen_sep = 1'b0;
            end else if (close_hit) begin
                n_in_frame = 1'b0;
                n_seen_sep = 1'b0;
            end else if (body_char && is_sep) begin
                n_seen_sep = 1'b1;
            end
            if (wr_en) begin
                n_new_data = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame     <= 1'b0;
            r_seen_sep     <= 1'b0;
            r_new_data     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_frame_done   <= 1'b0;
            r_frame_acc    <= 1'b0;
            r_out_new_data <= 1'b0;
        end else begin
            r_in_frame <= n_in_frame;
            r_seen_sep <= n_seen_sep;
            r_new_data <= n_new_data;
            if (accept) begin
                r_out_valid    <= 1'b1;
                r_frame_done   <= close_hit;
                r_frame_acc    <= wr_en;
                // A read reports the flag as it stood before clearing it.
                r_out_new_data <= is_read ? r_new_data : n_new_data;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_frame_done     = r_frame_done;
    assign o_frame_accepted = r_frame_acc;
    assign o_new_data       = r_out_new_data;

    `ACFP_ASSERT(a_acc_has_done, o_out_valid && o_frame_accepted |-> o_frame_done, "done missing")
    `ACFP_ASSERT(a_acc_sets_flag, o_out_valid && o_frame_accepted |-> o_new_data, "flag not set")
    `ACFP_ASSERT(a_read_clears, is_read |=> !r_new_data, "read did not clear new data")
    `ACFP_ASSERT(a_ready_when_empty, !r_out_valid |-> o_in_ready, "stalled while empty")
    `ACFP_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule
`default_nettype wire

// ===== hw/rtl/acfp_ram.sv =====
`default_nettype none
module acfp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== hw/rtl/acfp_num_feed.sv =====
`default_nettype none
// Decimal number scanner: skips whitespace, takes one optional sign,
// then accumulates digits until the first non-digit.
module acfp_num_feed #(
    parameter int ACC_W    = 16,
    parameter bit SATURATE = 1'b0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clear,
    input  wire logic             i_feed,
    input  wire logic [7:0]       i_char,
    output logic                  o_neg,
    output logic      [ACC_W-1:0] o_acc
);

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SIGN,
        PH_DIGITS,
        PH_STOP
    } t_phase;

    t_phase             r_phase, n_phase;
    logic               r_neg, n_neg;
    logic [ACC_W-1:0]   r_acc, n_acc;

    logic               is_digit;
    logic               is_ws;
    logic               is_sign;
    logic [ACC_W+3:0]   prod;
    logic [ACC_W-1:0]   acc_next;

    assign is_digit = (i_char >= acfp_pkg::CHAR_ZERO) && (i_char <= acfp_pkg::CHAR_NINE);
    assign is_ws    = (i_char == acfp_pkg::CHAR_SPACE)
                   || ((i_char >= acfp_pkg::CHAR_TAB) && (i_char <= acfp_pkg::CHAR_CR));
    assign is_sign  = (i_char == acfp_pkg::CHAR_PLUS) || (i_char == acfp_pkg::CHAR_MINUS);

    // acc * 10 + digit; the product cannot exceed ACC_W + 4 bits.
    assign prod = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                + (ACC_W + 4)'(i_char[3:0]);

    always_comb begin
        if (SATURATE && (prod[ACC_W+3:ACC_W] != 4'b0)) begin
            acc_next = '1;
        end else begin
            acc_next = prod[ACC_W-1:0];
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        if (i_clear) begin
            n_phase = PH_SKIP;
            n_neg   = 1'b0;
            n_acc   = '0;
        end else if (i_feed) begin
            case (r_phase)
                PH_SKIP: begin
                    if (is_ws) begin
                        n_phase = PH_SKIP;
                    end else if (is_sign) begin
                        n_neg   = (i_char == acfp_pkg::CHAR_MINUS);
                        n_phase = PH_SIGN;
                    end else if (is_digit) begin
                        n_phase = PH_DIGITS;
                        n_acc   = acc_next;
                    end else begin
                        n_phase = PH_STOP;
                    end
                end
                PH_SIGN, PH_DIGITS: begin
                    if (is_digit) begin
                        n_phase = PH_DIGITS;
                        n_acc   = acc_next;
                    end else begin
                        n_phase = PH_STOP;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_neg   <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
        end
    end

    assign o_neg = r_neg;
    assign o_acc = r_acc;

endmodule
`default_nettype wire

// ===== hw/rtl/acfp_store.sv =====
`default_nettype none
// Actuator value store: RAM plus one valid bit per slot, so that a slot
// never written since reset or the last count write reads as zero.
module acfp_store #(
    parameter int ACT_MAX    = acfp_pkg::ACT_MAX_DEF,
    parameter int VALUE_BITS = acfp_pkg::VALUE_BITS_DEF,
    localparam int AW = (ACT_MAX > 1) ? $clog2(ACT_MAX) : 1
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [acfp_pkg::COUNT_W-1:0]      i_cfg_data,
    input  wire logic                              i_wr_en,
    input  wire logic [AW-1:0]                     i_wr_addr,
    input  wire logic [VALUE_BITS-1:0]             i_wr_data,
    input  wire logic                              i_rd_en,
    input  wire logic                              i_rd_sel,
    input  wire logic [acfp_pkg::READ_IDX_W-1:0]   i_rd_idx,
    output logic      [acfp_pkg::COUNT_W-1:0]      o_count,
    output logic signed [acfp_pkg::OUT_W-1:0]      o_rd_value
);

    logic [acfp_pkg::COUNT_W-1:0] r_count, n_count;
    logic                         r_valid [ACT_MAX];
    logic                         r_rd_ok;
    logic [VALUE_BITS-1:0]        rd_data;
    logic signed [VALUE_BITS-1:0] rd_signed;
    logic                         rd_in_range;
    logic [AW-1:0]                rd_addr;

    assign rd_addr     = AW'(i_rd_idx);
    assign rd_in_range = (int'(i_rd_idx) < ACT_MAX);

    always_comb begin
        if (int'(i_cfg_data) > ACT_MAX) begin
            n_count = acfp_pkg::COUNT_W'(ACT_MAX);
        end else begin
            n_count = i_cfg_data;
        end
    end

    acfp_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (ACT_MAX)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr_en),
        .i_waddr (i_wr_addr),
        .i_wdata (i_wr_data),
        .i_re    (i_rd_en && i_rd_sel && rd_in_range),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rd_ok <= 1'b0;
            for (int i = 0; i < ACT_MAX; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_count <= n_count;
                for (int i = 0; i < ACT_MAX; i++) begin
                    r_valid[i] <= 1'b0;
                end
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= i_rd_sel && rd_in_range && r_valid[rd_addr];
            end
        end
    end

    assign rd_signed  = rd_data;
    assign o_count    = r_count;
    assign o_rd_value = r_rd_ok ? acfp_pkg::OUT_W'(rd_signed) : '0;

endmodule
`default_nettype wire
